// File: rtl/core/mgrt_pkg.sv
// ----------------------------------------------------------------------------
// mgrt_pkg: shared types and constants of the motion gated rate threshold
// Field widths, the threshold reset value and the result record carried
// between the detector core and its output queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mgrt_pkg;

  // Field widths
  localparam int unsigned SampleW = 32;
  localparam int unsigned PosW    = 32;
  localparam int unsigned ThreshW = 32;

  // Packed stream widths, padded to whole bytes
  localparam int unsigned InDataW  = 96;
  localparam int unsigned OutDataW = 8;

  // Threshold after reset: 0.00005 in unsigned Q0.32
  localparam logic [ThreshW-1:0] ThresholdReset = 32'd214748;

  // One result item
  typedef struct packed {
    logic grass_present;
  } result_t;

endpackage : mgrt_pkg

`default_nettype wire

// File: rtl/core/mgrt_result_fifo.sv
// ----------------------------------------------------------------------------
// mgrt_result_fifo: two-entry result queue
// Holds finished results so the detector keeps taking input transactions
// while the downstream side stalls. Head entry drives the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mgrt_result_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire mgrt_pkg::result_t push_data_i,
  output logic                  full_o,
  output logic                  valid_o,
  output mgrt_pkg::result_t     data_o,
  input  wire logic             ready_i
);
  import mgrt_pkg::*;

  logic [1:0] count_q, count_d;
  result_t    slot0_q, slot1_q;
  logic       pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign data_o  = slot0_q;

  // Track fill level
  always_comb begin
    count_d = count_q;
    unique case ({push_i, pop})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  // Move entries: head at slot0, advance slot1 on pop
  always_ff @(posedge clk_i) begin
    unique case ({push_i, pop})
      2'b10: begin
        if (count_q == 2'd0) begin
          slot0_q <= push_data_i;
        end else begin
          slot1_q <= push_data_i;
        end
      end
      2'b01: begin
        slot0_q <= slot1_q;
      end
      2'b11: begin
        if (count_q == 2'd1) begin
          slot0_q <= push_data_i;
        end else begin
          slot0_q <= slot1_q;
          slot1_q <= push_data_i;
        end
      end
      default: begin
        slot0_q <= slot0_q;
      end
    endcase
  end

endmodule : mgrt_result_fifo

`default_nettype wire

// File: rtl/core/motion_gated_rate_threshold.sv
// Result path: a result is registered in the result queue and presented on the master
//   side behind any results already queued; an input transaction causes zero or one result.
// Throughput: one input transaction per cycle, with the running sum read, modified and
//   written back in place; input stalls only when both result queue entries are occupied.
//   Reset clears detector state and the queue fill level at once, no sweep.
// ----------------------------------------------------------------------------
// motion_gated_rate_threshold: motion gated moving-sum threshold detector
// Counts a coverage sample only when the position moved, keeps a window of
// sample differences and its running sum, and reports flag changes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module motion_gated_rate_threshold #(
  parameter int unsigned WINDOW_LENGTH = 10
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // Configuration: threshold register
  input  wire logic                        cfg_we_i,
  input  wire logic [mgrt_pkg::ThreshW-1:0] cfg_wdata_i,
  // Input stream
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // [31:0] coverage_sample, [63:32] position_x, [95:64] position_y
  input  wire logic [mgrt_pkg::InDataW-1:0] s_axis_tdata,
  // Result stream
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // [0] grass_present, [7:1] zero
  output logic [mgrt_pkg::OutDataW-1:0]    m_axis_tdata
);
  import mgrt_pkg::*;

  localparam int unsigned DiffW = SampleW + 1;
  localparam int unsigned SumW  = DiffW + $clog2(WINDOW_LENGTH);
  localparam logic [SumW-1:0] LimitReset =
    SumW'(WINDOW_LENGTH) * SumW'(ThresholdReset);

  // Field unpacking
  logic [SampleW-1:0] sample;
  logic [PosW-1:0]    pos_x, pos_y;

  assign sample = s_axis_tdata[SampleW-1:0];
  assign pos_x  = s_axis_tdata[SampleW +: PosW];
  assign pos_y  = s_axis_tdata[SampleW+PosW +: PosW];

  // State
  logic [SampleW-1:0]          prev_sample_q;
  logic [PosW-1:0]             prev_x_q, prev_y_q;
  logic signed [DiffW-1:0]     diff_line_q [WINDOW_LENGTH];
  logic signed [SumW-1:0]      sum_q, sum_d;
  logic [SumW-1:0]             limit_q;
  logic                        detected_q;

  logic                        accept, moved, count_en, above, fifo_full, push;
  logic signed [DiffW-1:0]     diff;
  result_t                     push_data, head;

  assign s_axis_tready = !fifo_full;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign moved         = (pos_x != prev_x_q) || (pos_y != prev_y_q);
  assign count_en      = accept && moved;

  // Difference, running sum update and threshold compare
  assign diff  = $signed({1'b0, sample}) - $signed({1'b0, prev_sample_q});
  assign sum_d = sum_q - SumW'(diff_line_q[WINDOW_LENGTH-1]) + SumW'(diff);
  assign above = sum_d > $signed(limit_q);

  assign push                    = count_en && (above != detected_q);
  assign push_data.grass_present = above;

  // Scale threshold by the window length on each register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_we_i) begin
      limit_q <= SumW'(WINDOW_LENGTH) * SumW'(cfg_wdata_i);
    end
  end

  // Update detector state on each counted sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_sample_q <= '0;
      prev_x_q      <= '0;
      prev_y_q      <= '0;
      sum_q         <= '0;
      detected_q    <= 1'b0;
    end else if (count_en) begin
      prev_sample_q <= sample;
      prev_x_q      <= pos_x;
      prev_y_q      <= pos_y;
      sum_q         <= sum_d;
      detected_q    <= above;
    end
  end

  // Shift the difference window; the oldest entry drops off the far end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_LENGTH; i++) begin
        diff_line_q[i] <= '0;
      end
    end else if (count_en) begin
      diff_line_q[0] <= diff;
      for (int i = 1; i < WINDOW_LENGTH; i++) begin
        diff_line_q[i] <= diff_line_q[i-1];
      end
    end
  end

  // Result queue toward the master side
  mgrt_result_fifo u_result_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (fifo_full),
    .valid_o     (m_axis_tvalid),
    .data_o      (head),
    .ready_i     (m_axis_tready)
  );

  assign m_axis_tdata = {{(OutDataW-1){1'b0}}, head.grass_present};

endmodule : motion_gated_rate_threshold

`default_nettype wire
